// File: rtl/ltms_pkg.sv
// ----------------------------------------------------------------------------
// Line-track mode sequencer package
// Mode, action and pattern codes, register indexes and the angle wrap helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ltms_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_CROSS  = 3'd1,
        MODE_TURN   = 3'd2,
        MODE_RING   = 3'd3,
        MODE_COOL   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ACT_FOLLOW = 2'd0,
        ACT_HOLD   = 2'd1,
        ACT_TURN   = 2'd2
    } t_action;

    // Line pattern codes
    localparam logic [2:0] PAT_LOST       = 3'd1;
    localparam logic [2:0] PAT_CROSS      = 3'd2;
    localparam logic [2:0] PAT_FULL_BLACK = 3'd3;
    localparam logic [2:0] PAT_LEFT_SHARP = 3'd4;
    localparam logic [2:0] PAT_RIGHT_SHARP = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_EVENT_STABLE  = 3'd0;
    localparam logic [2:0] REG_CROSS_PASS    = 3'd1;
    localparam logic [2:0] REG_TURN_STABLE   = 3'd2;
    localparam logic [2:0] REG_COOLDOWN      = 3'd3;
    localparam logic [2:0] REG_RING_MIN      = 3'd4;
    localparam logic [2:0] REG_RING_TIMEOUT  = 3'd5;
    localparam logic [2:0] REG_TURN_ANGLE    = 3'd6;
    localparam logic [2:0] REG_TURN_TOL      = 3'd7;

    localparam logic signed [17:0] ANG_HALF  = 18'sd18000;
    localparam logic signed [17:0] ANG_FULL  = 18'sd36000;
    localparam logic signed [17:0] ANG_1P5   = 18'sd54000;
    localparam logic signed [17:0] ANG_FULL2 = 18'sd72000;

    // Wrap a value in [-65536, 65535] into [-18000, 18000).
    function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] v);
        logic signed [17:0] r;
        if (v >= ANG_1P5) begin
            r = v - ANG_FULL2;
        end else if (v >= ANG_HALF) begin
            r = v - ANG_FULL;
        end else if (v < -ANG_1P5) begin
            r = v + ANG_FULL2;
        end else if (v < -ANG_HALF) begin
            r = v + ANG_FULL;
        end else begin
            r = v;
        end
        return $signed(r[15:0]);
    endfunction

endpackage

`default_nettype wire

// File: rtl/line_track_mode_sequencer_core.sv
// ----------------------------------------------------------------------------
// Line-track mode sequencer core
// Debounces line patterns into cross, turn and roundabout modes and reports
// the drive action and heading target for each control tick.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transfer per control tick, carrying the line pattern
//   and the gyro yaw. Master stream: one transfer per tick with the drive
//   action and heading target picked by the mode held at the start of that
//   tick, plus the mode after it. Configuration writes go through the plain
//   write port (enable, index, data) and take effect at the next edge; write
//   them only while no tick is in flight.
//   A result passes the input register, then the result register, after its
//   input transfer. Throughput: one tick per cycle unless the receiver stalls;
//   the mode update is a few compares and two wrap adds between the registers.
//   Reset (synchronous, active low) restores the default registers, returns
//   to normal mode with all counts and headings cleared, and empties both
//   register stages.
//   When the receiver stalls, the result register holds and the input stage
//   holds one more tick; s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module line_track_mode_sequencer_core
    import ltms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    // Slave stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [2:0] line_pattern, [18:3] yaw_angle
    // Master stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata    // [1:0] drive_action,
                                             // [17:2] heading_target, [20:18] mode_after
);

    // ---------------- configuration registers ----------------
    logic [7:0]  r_event_stable;
    logic [15:0] r_cross_pass;
    logic [7:0]  r_turn_stable;
    logic [15:0] r_cooldown;
    logic [15:0] r_ring_min;
    logic [15:0] r_ring_timeout;
    logic [14:0] r_turn_angle;
    logic [14:0] r_turn_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_stable <= 8'd3;
            r_cross_pass   <= 16'd25;
            r_turn_stable  <= 8'd3;
            r_cooldown     <= 16'd30;
            r_ring_min     <= 16'd60;
            r_ring_timeout <= 16'd220;
            r_turn_angle   <= 15'd7500;
            r_turn_tol     <= 15'd300;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_EVENT_STABLE: r_event_stable <= i_cfg_wdata[7:0];
                REG_CROSS_PASS:   r_cross_pass   <= i_cfg_wdata;
                REG_TURN_STABLE:  r_turn_stable  <= i_cfg_wdata[7:0];
                REG_COOLDOWN:     r_cooldown     <= i_cfg_wdata;
                REG_RING_MIN:     r_ring_min     <= i_cfg_wdata;
                REG_RING_TIMEOUT: r_ring_timeout <= i_cfg_wdata;
                REG_TURN_ANGLE:   r_turn_angle   <= i_cfg_wdata[14:0];
                REG_TURN_TOL:     r_turn_tol     <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic        r_in_valid;
    logic [2:0]  r_in_pat;
    logic signed [15:0] r_in_yaw;
    logic        r_out_valid;
    t_action     r_out_action;
    logic signed [15:0] r_out_target;
    t_mode       r_out_mode;
    logic        w_adv;

    // Advance the input stage whenever the result register is free or drains.
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_pat <= s_axis_tdata[2:0];
            r_in_yaw <= $signed(s_axis_tdata[18:3]);
        end
    end

    // ---------------- sequencer state ----------------
    t_mode       r_mode, n_mode;
    logic [7:0]  r_debounce, n_debounce;
    logic [15:0] r_ticks, n_ticks;
    logic signed [15:0] r_locked, n_locked;
    logic signed [15:0] r_target, n_target;

    logic [7:0]  w_deb_inc;
    logic [15:0] w_ticks_inc;
    logic signed [17:0] w_yaw_x;
    logic signed [17:0] w_ang_x;
    logic signed [15:0] w_new_target;
    logic signed [15:0] w_err;
    logic signed [15:0] w_tol;
    logic        w_in_tol;
    t_action     w_action;
    logic signed [15:0] w_head;

    // Saturating bumps of the two counts
    assign w_deb_inc   = (r_debounce == 8'hFF) ? r_debounce : r_debounce + 8'd1;
    assign w_ticks_inc = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;

    // Turn target: yaw plus the angle for a left sharp, minus it for a right sharp
    assign w_yaw_x      = {{2{r_in_yaw[15]}}, r_in_yaw};
    assign w_ang_x      = $signed({3'b000, r_turn_angle});
    assign w_new_target = wrap_angle((r_in_pat == PAT_LEFT_SHARP) ?
                                     w_yaw_x + w_ang_x : w_yaw_x - w_ang_x);

    // Heading error against the stored turn target, bound is exclusive
    assign w_err    = wrap_angle({{2{r_target[15]}}, r_target} - w_yaw_x);
    assign w_tol    = $signed({1'b0, r_turn_tol});
    assign w_in_tol = (w_err > -w_tol) && (w_err < w_tol);

    // Next state
    always_comb begin
        n_mode     = r_mode;
        n_debounce = r_debounce;
        n_ticks    = r_ticks;
        n_locked   = r_locked;
        n_target   = r_target;
        case (r_mode)
            MODE_NORMAL: begin
                if (r_in_pat >= PAT_CROSS) begin
                    n_debounce = w_deb_inc;
                    if (w_deb_inc >= r_event_stable) begin
                        if (r_in_pat <= PAT_FULL_BLACK) begin
                            n_locked = r_in_yaw;
                            n_mode   = MODE_CROSS;
                        end else if (r_in_pat <= PAT_RIGHT_SHARP) begin
                            n_target = w_new_target;
                            n_mode   = MODE_TURN;
                        end else begin
                            n_mode = MODE_RING;
                        end
                        n_ticks    = 16'd0;
                        n_debounce = 8'd0;
                    end
                end else begin
                    n_debounce = 8'd0;
                end
            end
            MODE_CROSS: begin
                n_ticks = w_ticks_inc;
                if (w_ticks_inc >= r_cross_pass) begin
                    n_mode  = MODE_COOL;
                    n_ticks = 16'd0;
                end
            end
            MODE_TURN: begin
                if (w_in_tol) begin
                    n_debounce = w_deb_inc;
                    if (w_deb_inc >= r_turn_stable) begin
                        n_mode     = MODE_COOL;
                        n_ticks    = 16'd0;
                        n_debounce = 8'd0;
                    end
                end else begin
                    n_debounce = 8'd0;
                end
            end
            MODE_RING: begin
                n_ticks = w_ticks_inc;
                // Exit on a plain or lost line once past the minimum, else on timeout
                if ((w_ticks_inc >= r_ring_min) &&
                    ((r_in_pat <= PAT_LOST) || (w_ticks_inc >= r_ring_timeout))) begin
                    n_mode  = MODE_COOL;
                    n_ticks = 16'd0;
                end
            end
            MODE_COOL: begin
                n_ticks = w_ticks_inc;
                if (w_ticks_inc >= r_cooldown) begin
                    n_mode     = MODE_NORMAL;
                    n_ticks    = 16'd0;
                    n_debounce = 8'd0;
                end
            end
            default: begin
                n_mode     = MODE_NORMAL;
                n_ticks    = 16'd0;
                n_debounce = 8'd0;
            end
        endcase
    end

    // Outputs chosen by the mode held at the start of the tick
    always_comb begin
        case (r_mode)
            MODE_CROSS: begin
                w_action = ACT_HOLD;
                w_head   = r_locked;
            end
            MODE_TURN: begin
                w_action = ACT_TURN;
                w_head   = r_target;
            end
            default: begin
                w_action = ACT_FOLLOW;
                w_head   = 16'sd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_NORMAL;
            r_debounce <= 8'd0;
            r_ticks    <= 16'd0;
            r_locked   <= 16'sd0;
            r_target   <= 16'sd0;
        end else if (w_adv) begin
            r_mode     <= n_mode;
            r_debounce <= n_debounce;
            r_ticks    <= n_ticks;
            r_locked   <= n_locked;
            r_target   <= n_target;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_action <= w_action;
            r_out_target <= w_head;
            r_out_mode   <= n_mode;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_mode, r_out_target, r_out_action};

    // ---------------- assertions ----------------
    a_follow_zero_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_action == ACT_FOLLOW)) |-> (r_out_target == 16'sd0))
        else $error("follow action with nonzero heading target");

    a_debounce_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_mode == MODE_CROSS) || (r_mode == MODE_RING) || (r_mode == MODE_COOL))
        |-> (r_debounce == 8'd0))
        else $error("debounce count left over outside normal and turn modes");

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_TURN) |-> ((r_target >= -16'sd18000) && (r_target < 16'sd18000)))
        else $error("turn target outside wrapped range");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_mode) && $stable(r_ticks) && $stable(r_debounce)))
        else $error("sequencer state moved without a tick");

endmodule

`default_nettype wire
